FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the execute block.
// No dependencies; each file that asserts takes this in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(LBL, CLK, RST, EXPR, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RST) (EXPR)) \
        else $error(MSG);

// Check that an antecedent implies a consequent sequence.
`define ASSERT_IMPLIES(LBL, CLK, RST, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RST) (ANTE) |-> (CONS)) \
        else $error(MSG);

`endif

FILE: rtl/trm_pkg.sv
// Types, instruction codes and helpers for the register machine execute block.
// No dependencies; imported by every module of the block except trm_ram.
package trm_pkg;

    localparam int ADDR_W    = 10;
    localparam int KIND_W    = 5;
    localparam int REG_AW    = 4;
    localparam int REG_SLOTS = 16;
    localparam int WORD_W    = 32;
    localparam int ADV_W     = 4;

    localparam logic [REG_AW-1:0] R0_IDX = '0;

    localparam logic [KIND_W-1:0] KIND_HALT          = 5'd0;
    localparam logic [KIND_W-1:0] KIND_MOV_LIT_REG   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_MOV_REG_REG   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_STORE_LIT_MEM = 5'd3;
    localparam logic [KIND_W-1:0] KIND_STORE_REG_MEM = 5'd4;
    localparam logic [KIND_W-1:0] KIND_STORE_MEM_MEM = 5'd5;
    localparam logic [KIND_W-1:0] KIND_LOAD_MEM_REG  = 5'd6;
    localparam logic [KIND_W-1:0] KIND_ADD_LIT_REG   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_ADD_REG_REG   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_SUB_LIT_REG   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_SUB_REG_REG   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_INC_REG       = 5'd11;
    localparam logic [KIND_W-1:0] KIND_INC_MEM       = 5'd12;
    localparam logic [KIND_W-1:0] KIND_DEC_REG       = 5'd13;
    localparam logic [KIND_W-1:0] KIND_DEC_MEM       = 5'd14;
    localparam logic [KIND_W-1:0] KIND_JMP           = 5'd15;
    localparam logic [KIND_W-1:0] KIND_JMP_NE        = 5'd16;
    localparam logic [KIND_W-1:0] KIND_JMP_EQ        = 5'd17;
    localparam logic [KIND_W-1:0] KIND_JMP_GT        = 5'd18;
    localparam logic [KIND_W-1:0] KIND_JMP_LT        = 5'd19;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL       = 5'd20;
    localparam logic [KIND_W-1:0] KIND_START         = 5'd21;

    // Instruction pointer advance per instruction length
    localparam logic [ADV_W-1:0] ADV_HALT  = 4'd1;
    localparam logic [ADV_W-1:0] ADV_TINY  = 4'd2;
    localparam logic [ADV_W-1:0] ADV_SHORT = 4'd3;
    localparam logic [ADV_W-1:0] ADV_MEMRW = 4'd5;
    localparam logic [ADV_W-1:0] ADV_MID   = 4'd6;
    localparam logic [ADV_W-1:0] ADV_LONG  = 4'd9;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] literal;
        logic [REG_AW-1:0] src_reg;
        logic [REG_AW-1:0] dst_reg;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] second_address;
    } trm_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] next_ip;
        logic              still_running;
        logic [REG_AW-1:0] changed_reg;
        logic [WORD_W-1:0] changed_value;
        logic [WORD_W-1:0] r0_value;
    } trm_out_t;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } trm_rf_wr_t;

    typedef struct packed {
        trm_rf_wr_t        rf;
        logic              mem_we;
        logic              mem_second;
        logic [WORD_W-1:0] mem_wdata;
    } trm_wb_t;

    // Reduce a word address modulo the memory depth by conditional subtraction
    // of the depth scaled by descending powers of two.
    function automatic logic [ADDR_W-1:0] addr_wrap(input logic [ADDR_W-1:0] a,
                                                    input int unsigned words);
        logic [ADDR_W:0] r;
        longint unsigned sh;
        r = {1'b0, a};
        for (int k = ADDR_W - 1; k >= 0; k--) begin
            sh = longint'(words) << k;
            if (sh < (longint'(1) << ADDR_W)) begin
                if (r >= sh[ADDR_W:0]) begin
                    r = r - sh[ADDR_W:0];
                end
            end
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/trm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/trm_regfile.sv
// Register file: two RAM copies for the source and destination read ports,
// per-entry valid bits for the zero reset, and same-edge write forwarding.
// Depends on trm_pkg and trm_ram.
module trm_regfile
    import trm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [REG_AW-1:0] rd_src,
    input  logic [REG_AW-1:0] rd_dst,
    input  trm_rf_wr_t        wr,
    output logic [WORD_W-1:0] src_data,
    output logic [WORD_W-1:0] dst_data
);

    logic [REG_SLOTS-1:0] vld_reg;
    logic                 src_byp_reg;
    logic [WORD_W-1:0]    src_byp_data_reg;
    logic                 dst_byp_reg;
    logic [WORD_W-1:0]    dst_byp_data_reg;
    logic [WORD_W-1:0]    src_q;
    logic [WORD_W-1:0]    dst_q;
    logic                 src_hit;
    logic                 dst_hit;

    trm_ram #(.WIDTH(WORD_W), .DEPTH(REG_SLOTS)) u_ram_src (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_src),
        .rdata (src_q)
    );

    trm_ram #(.WIDTH(WORD_W), .DEPTH(REG_SLOTS)) u_ram_dst (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_dst),
        .rdata (dst_q)
    );

    assign src_hit = wr.we && (wr.addr == rd_src);
    assign dst_hit = wr.we && (wr.addr == rd_dst);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.we)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // Take the word being written this edge, or zero for a never-written entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            src_byp_reg      <= src_hit || !vld_reg[rd_src];
            src_byp_data_reg <= src_hit ? wr.data : '0;
            dst_byp_reg      <= dst_hit || !vld_reg[rd_dst];
            dst_byp_data_reg <= dst_hit ? wr.data : '0;
        end
    end

    assign src_data = src_byp_reg ? src_byp_data_reg : src_q;
    assign dst_data = dst_byp_reg ? dst_byp_data_reg : dst_q;

endmodule

FILE: rtl/trm_exec.sv
// Execute logic: resolves register operands, runs the shared adder, computes
// the next instruction pointer, run flag and write-back.
// Depends on trm_pkg.
module trm_exec
    import trm_pkg::*;
#(
    parameter int NUM_REGS = 16,
    localparam int IDX_W   = (NUM_REGS > REG_SLOTS) ? $clog2(NUM_REGS) : REG_AW
) (
    input  trm_in_t           item,
    input  logic [WORD_W-1:0] src_raw,
    input  logic [WORD_W-1:0] dst_raw,
    input  logic [WORD_W-1:0] mem_rd,
    input  logic [WORD_W-1:0] ip,
    input  logic [WORD_W-1:0] acc,
    input  logic [WORD_W-1:0] r0,
    input  logic              run,
    input  logic [IDX_W-1:0]  last,
    input  logic [WORD_W-1:0] last_val,
    output trm_wb_t           wb,
    output logic [WORD_W-1:0] ip_next,
    output logic [WORD_W-1:0] acc_next,
    output logic [WORD_W-1:0] r0_next,
    output logic              run_next,
    output logic [IDX_W-1:0]  last_next,
    output logic [WORD_W-1:0] last_val_next,
    output logic [WORD_W-1:0] changed_value
);

    localparam logic [IDX_W-1:0] IP_IDX  = IDX_W'(NUM_REGS - 1);
    localparam logic [IDX_W-1:0] ACC_IDX = IDX_W'(NUM_REGS - 2);
    localparam logic [IDX_W-1:0] R0_X    = IDX_W'(R0_IDX);
    localparam logic [IDX_W:0]   NREG    = (IDX_W + 1)'(NUM_REGS);

    logic [IDX_W-1:0]  src_x;
    logic [IDX_W-1:0]  dst_x;
    logic              src_ok;
    logic              dst_ok;
    logic [WORD_W-1:0] src_val;
    logic [WORD_W-1:0] dst_val;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
    logic              neg;
    logic [WORD_W-1:0] value;
    logic [ADV_W-1:0]  adv;
    logic              is_reg;
    logic              is_mem;
    logic              is_jump;
    logic              take;
    logic              is_start;
    logic              is_halt;
    logic              mem_second;
    logic [WORD_W-1:0] ip_base;
    logic [WORD_W-1:0] ip_adv;
    logic [WORD_W-1:0] target;

    assign src_x  = IDX_W'(item.src_reg);
    assign dst_x  = IDX_W'(item.dst_reg);
    assign src_ok = {1'b0, src_x} < NREG;
    assign dst_ok = {1'b0, dst_x} < NREG;
    assign target = WORD_W'(item.address);

    // The pointer, accumulator and R0 live in flops; out-of-range reads give zero
    always_comb
    begin
        if (!src_ok)
            src_val = '0;
        else if (src_x == IP_IDX)
            src_val = ip;
        else if (src_x == ACC_IDX)
            src_val = acc;
        else if (src_x == R0_X)
            src_val = r0;
        else
            src_val = src_raw;

        if (!dst_ok)
            dst_val = '0;
        else if (dst_x == IP_IDX)
            dst_val = ip;
        else if (dst_x == ACC_IDX)
            dst_val = acc;
        else if (dst_x == R0_X)
            dst_val = r0;
        else
            dst_val = dst_raw;
    end

    always_comb
    begin
        opa        = item.literal;
        opb        = '0;
        neg        = 1'b0;
        adv        = ADV_HALT;
        is_reg     = 1'b0;
        is_mem     = 1'b0;
        is_jump    = 1'b0;
        take       = 1'b0;
        is_start   = 1'b0;
        is_halt    = 1'b0;
        mem_second = 1'b0;
        unique case (item.kind)
            KIND_MOV_LIT_REG:
            begin
                is_reg = 1'b1;
                adv    = ADV_MID;
            end
            KIND_MOV_REG_REG:
            begin
                is_reg = 1'b1;
                opa    = src_val;
                adv    = ADV_SHORT;
            end
            KIND_STORE_LIT_MEM:
            begin
                is_mem = 1'b1;
                adv    = ADV_LONG;
            end
            KIND_STORE_REG_MEM:
            begin
                is_mem = 1'b1;
                opa    = src_val;
                adv    = ADV_MID;
            end
            KIND_STORE_MEM_MEM:
            begin
                is_mem     = 1'b1;
                mem_second = 1'b1;
                opa        = mem_rd;
                adv        = ADV_LONG;
            end
            KIND_LOAD_MEM_REG:
            begin
                is_reg = 1'b1;
                opa    = mem_rd;
                adv    = ADV_MID;
            end
            KIND_ADD_LIT_REG:
            begin
                is_reg = 1'b1;
                opa    = dst_val;
                opb    = item.literal;
                adv    = ADV_MID;
            end
            KIND_ADD_REG_REG:
            begin
                is_reg = 1'b1;
                opa    = dst_val;
                opb    = src_val;
                adv    = ADV_SHORT;
            end
            KIND_SUB_LIT_REG:
            begin
                is_reg = 1'b1;
                opa    = dst_val;
                opb    = item.literal;
                neg    = 1'b1;
                adv    = ADV_MID;
            end
            KIND_SUB_REG_REG:
            begin
                is_reg = 1'b1;
                opa    = dst_val;
                opb    = src_val;
                neg    = 1'b1;
                adv    = ADV_SHORT;
            end
            KIND_INC_REG:
            begin
                is_reg = 1'b1;
                opa    = dst_val;
                opb    = WORD_W'(1);
                adv    = ADV_TINY;
            end
            KIND_DEC_REG:
            begin
                is_reg = 1'b1;
                opa    = dst_val;
                opb    = WORD_W'(1);
                neg    = 1'b1;
                adv    = ADV_TINY;
            end
            KIND_INC_MEM:
            begin
                is_mem = 1'b1;
                opa    = mem_rd;
                opb    = WORD_W'(1);
                adv    = ADV_MEMRW;
            end
            KIND_DEC_MEM:
            begin
                is_mem = 1'b1;
                opa    = mem_rd;
                opb    = WORD_W'(1);
                neg    = 1'b1;
                adv    = ADV_MEMRW;
            end
            KIND_JMP:
            begin
                is_jump = 1'b1;
                take    = 1'b1;
                adv     = ADV_MID;
            end
            KIND_JMP_NE:
            begin
                is_jump = 1'b1;
                take    = (acc != src_val);
                adv     = ADV_MID;
            end
            KIND_JMP_EQ:
            begin
                is_jump = 1'b1;
                take    = (acc == src_val);
                adv     = ADV_MID;
            end
            KIND_JMP_GT:
            begin
                is_jump = 1'b1;
                take    = (acc > src_val);
                adv     = ADV_MID;
            end
            KIND_JMP_LT:
            begin
                is_jump = 1'b1;
                take    = (acc < src_val);
                adv     = ADV_MID;
            end
            KIND_START:
            begin
                is_start = 1'b1;
            end
            default:
            begin
                is_halt = 1'b1;
            end
        endcase
    end

    assign value = neg ? (opa - opb) : (opa + opb);

    // A register write to the pointer lands first, then the advance is added
    assign ip_base = (is_reg && (dst_x == IP_IDX)) ? value : ip;
    assign ip_adv  = ip_base + WORD_W'(adv);

    always_comb
    begin
        if (is_start || (is_jump && take))
            ip_next = target;
        else
            ip_next = ip_adv;

        if (is_start)
            run_next = 1'b1;
        else if (is_halt)
            run_next = 1'b0;
        else
            run_next = run;

        if (is_reg)
            last_next = dst_x;
        else if (is_start)
            last_next = last;
        else
            last_next = IP_IDX;

        if (is_reg)
            last_val_next = dst_ok ? value : '0;
        else
            last_val_next = last_val;
    end

    assign acc_next = (is_reg && (dst_x == ACC_IDX)) ? value : acc;
    assign r0_next  = (is_reg && (dst_x == R0_X)) ? value : r0;

    assign changed_value = (last_next == IP_IDX) ? ip_next : last_val_next;

    assign wb.rf.we      = is_reg && dst_ok;
    assign wb.rf.addr    = item.dst_reg;
    assign wb.rf.data    = value;
    assign wb.mem_we     = is_mem;
    assign wb.mem_second = mem_second;
    assign wb.mem_wdata  = value;

endmodule

FILE: rtl/toy_register_machine_execute_top.sv
// Top level of the register machine execute block: read stage, data memory,
// architectural flops and the result register.
// Depends on trm_pkg, trm_ram, trm_regfile and trm_exec.
//
// Usage: each beat on the item channel (item_valid/item_stall/item) is one
// decoded instruction; each beat on the result channel (res_valid/res_stall/
// res) reports the pointer, run flag, last changed register and R0 after it.
// Exactly one result beat follows every item beat, in order.
// A taken item is held in the read stage registers, then executed into the
// result register; execute waits while a stalled result holds that register.
// Throughput: one item per cycle while the result side is not stalled; the
// register and data memory reads are issued as the item is taken, the write-back
// of the item ahead is forwarded into them, so the pipeline never bubbles.
// The two-stage loop (synchronous read, then execute and write back) sets
// the latency; the execute adder chain sets the clock.
// Reset: all registers read zero, the machine is not running, the last
// changed index is R0; data memory words are undefined until written.
// Stall: a stalled result is held; one further item may be taken into the
// read stage, after which item_stall rises until the result is taken.
module toy_register_machine_execute_top
    import trm_pkg::*;
#(
    parameter int NUM_REGS  = 16,
    parameter int MEM_WORDS = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  trm_in_t  item,
    output logic     res_valid,
    input  logic     res_stall,
    output trm_out_t res
);

    localparam int IDX_W  = (NUM_REGS > REG_SLOTS) ? $clog2(NUM_REGS) : REG_AW;
    localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    trm_in_t             s1_item_reg;
    logic [MEM_AW-1:0]   s1_addr_reg;
    logic [MEM_AW-1:0]   s1_addr2_reg;
    logic                s1_mfwd_reg;
    logic [WORD_W-1:0]   s1_mfwd_data_reg;

    logic [WORD_W-1:0]   ip_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   r0_reg;
    logic                run_reg;
    logic [IDX_W-1:0]    last_reg;
    logic [WORD_W-1:0]   last_val_reg;

    logic                res_valid_reg;
    trm_out_t            res_reg;

    logic                accept;
    logic                exec_fire;
    logic [MEM_AW-1:0]   rd_addr;
    logic [MEM_AW-1:0]   rd_addr2;
    logic [MEM_AW-1:0]   mem_waddr;
    logic                mem_we;
    logic [WORD_W-1:0]   mem_q;
    logic [WORD_W-1:0]   mem_rd;
    trm_rf_wr_t          rf_wr;
    logic [WORD_W-1:0]   src_raw;
    logic [WORD_W-1:0]   dst_raw;

    trm_wb_t             wb;
    logic [WORD_W-1:0]   ip_next;
    logic [WORD_W-1:0]   acc_next;
    logic [WORD_W-1:0]   r0_next;
    logic                run_next;
    logic [IDX_W-1:0]    last_next;
    logic [WORD_W-1:0]   last_val_next;
    logic [WORD_W-1:0]   changed_value;

    // Handshake: execute when the result register is free or being drained
    assign exec_fire  = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign item_stall = s1_valid_reg && !exec_fire;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (exec_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign rd_addr  = MEM_AW'(addr_wrap(item.address, MEM_WORDS));
    assign rd_addr2 = MEM_AW'(addr_wrap(item.second_address, MEM_WORDS));

    assign mem_we    = exec_fire && wb.mem_we;
    assign mem_waddr = wb.mem_second ? s1_addr2_reg : s1_addr_reg;
    assign mem_rd    = s1_mfwd_reg ? s1_mfwd_data_reg : mem_q;

    trm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_data_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wb.mem_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    assign rf_wr.we   = exec_fire && wb.rf.we;
    assign rf_wr.addr = wb.rf.addr;
    assign rf_wr.data = wb.rf.data;

    trm_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_src   (item.src_reg),
        .rd_dst   (item.dst_reg),
        .wr       (rf_wr),
        .src_data (src_raw),
        .dst_data (dst_raw)
    );

    trm_exec #(.NUM_REGS(NUM_REGS)) u_exec (
        .item          (s1_item_reg),
        .src_raw       (src_raw),
        .dst_raw       (dst_raw),
        .mem_rd        (mem_rd),
        .ip            (ip_reg),
        .acc           (acc_reg),
        .r0            (r0_reg),
        .run           (run_reg),
        .last          (last_reg),
        .last_val      (last_val_reg),
        .wb            (wb),
        .ip_next       (ip_next),
        .acc_next      (acc_next),
        .r0_next       (r0_next),
        .run_next      (run_next),
        .last_next     (last_next),
        .last_val_next (last_val_next),
        .changed_value (changed_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            ip_reg        <= '0;
            acc_reg       <= '0;
            r0_reg        <= '0;
            run_reg       <= 1'b0;
            last_reg      <= '0;
            last_val_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (exec_fire)
            begin
                res_valid_reg <= 1'b1;
                ip_reg        <= ip_next;
                acc_reg       <= acc_next;
                r0_reg        <= r0_next;
                run_reg       <= run_next;
                last_reg      <= last_next;
                last_val_reg  <= last_val_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Catch a memory write that lands on the same edge as the read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg      <= item;
            s1_addr_reg      <= rd_addr;
            s1_addr2_reg     <= rd_addr2;
            s1_mfwd_reg      <= mem_we && (mem_waddr == rd_addr);
            s1_mfwd_data_reg <= wb.mem_wdata;
        end
        if (exec_fire)
        begin
            res_reg.next_ip       <= ip_next;
            res_reg.still_running <= run_next;
            res_reg.changed_reg   <= last_next[REG_AW-1:0];
            res_reg.changed_value <= changed_value;
            res_reg.r0_value      <= r0_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/trm_checker.sv
// Port-level checker for the register machine execute block, bound to the top.
// Depends on trm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trm_checker
    import trm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_stall,
    input  trm_in_t  item,
    input  logic     res_valid,
    input  logic     res_stall,
    input  trm_out_t res
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       item_beat;
    logic       res_beat;

    assign item_beat = item_valid && !item_stall;
    assign res_beat  = res_valid && !res_stall;

    // Count beats taken but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (item_beat && !res_beat)
            pend_next = pend_reg + 3'd1;
        else if (res_beat && !item_beat)
            pend_next = pend_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `ASSERT_IMPLIES(a_res_hold, clk, rst_n, res_valid && res_stall, ##1 (res_valid && $stable(res)), "stalled result beat changed")
    `ASSERT_ALWAYS(a_pend_bound, clk, rst_n, pend_reg <= 3'd2, "more than two items in flight")
    `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, res_valid, pend_reg != 3'd0, "result beat with no item outstanding")
    `ASSERT_IMPLIES(a_latency, clk, rst_n, item_beat && (pend_reg == 3'd0), ##2 res_valid, "result missing two cycles after idle entry")

endmodule

bind toy_register_machine_execute_top trm_checker u_trm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);

FILE: verif/toy_register_machine_execute_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for toy_register_machine_execute_top: directed table, then
// random programs under several idle patterns, each result checked against its table row or a predictor.
// Depends on trm_pkg and the RTL of the execute block.
module toy_register_machine_execute_top_tb;
    import trm_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 210;
    localparam int PRESSURE_ITEMS = 60;
    localparam int MEM_DEPTH      = 1 << ADDR_W;

    localparam logic [REG_AW-1:0] IP_REG  = REG_AW'(REG_SLOTS - 1);
    localparam logic [REG_AW-1:0] ACC_REG = REG_AW'(REG_SLOTS - 2);

    typedef struct {
        trm_in_t  ins;
        bit       has_want;
        trm_out_t want;
    } directed_row_t;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_stall;
    trm_in_t  item       = '0;
    logic     res_valid;
    logic     res_stall  = 1'b0;
    trm_out_t res;

    // architectural state of the predictor
    logic [WORD_W-1:0] arch_regs [REG_SLOTS];
    logic [WORD_W-1:0] data_mem  [MEM_DEPTH];
    logic              arch_running;
    logic [REG_AW-1:0] last_written;

    // generator bookkeeping: which data words hold a value
    bit word_written [MEM_DEPTH];
    int written_addrs [$];

    trm_out_t      expected_res_q [$];
    directed_row_t directed_rows [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    logic hold_on       = 1'b0;
    int  cycle_count    = 0;
    int  items_taken    = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  taken_branches = 0;
    int  longest_stall  = 0;

    toy_register_machine_execute_top #(
        .NUM_REGS  (REG_SLOTS),
        .MEM_WORDS (MEM_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results pending",
                     cycle_count, expected_res_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void write_reg(input logic [REG_AW-1:0] idx,
                                      input logic [WORD_W-1:0] value,
                                      input logic [ADV_W-1:0]  adv);
        last_written = idx;
        arch_regs[idx] = value;
        // a write to the pointer itself is advanced afterwards
        arch_regs[IP_REG] = arch_regs[IP_REG] + adv;
    endfunction

    function automatic void write_word(input logic [ADDR_W-1:0] addr,
                                       input logic [WORD_W-1:0] value,
                                       input logic [ADV_W-1:0]  adv);
        data_mem[addr] = value;
        arch_regs[IP_REG] = arch_regs[IP_REG] + adv;
        last_written = IP_REG;
    endfunction

    function automatic void branch(input bit take, input logic [ADDR_W-1:0] target);
        if (take)
        begin
            arch_regs[IP_REG] = WORD_W'(target);
            taken_branches++;
        end
        else
        begin
            arch_regs[IP_REG] = arch_regs[IP_REG] + ADV_MID;
        end
        last_written = IP_REG;
    endfunction

    function automatic trm_out_t execute_instr(input trm_in_t ins);
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] cmp;
        logic [WORD_W-1:0] src;
        logic [WORD_W-1:0] dst;
        logic [WORD_W-1:0] word;
        trm_out_t          r;
        acc  = arch_regs[ACC_REG];
        cmp  = arch_regs[ins.src_reg];
        src  = arch_regs[ins.src_reg];
        dst  = arch_regs[ins.dst_reg];
        word = data_mem[ins.address];
        case (ins.kind)
            KIND_MOV_LIT_REG:   write_reg(ins.dst_reg, ins.literal, ADV_MID);
            KIND_MOV_REG_REG:   write_reg(ins.dst_reg, src, ADV_SHORT);
            KIND_STORE_LIT_MEM: write_word(ins.address, ins.literal, ADV_LONG);
            KIND_STORE_REG_MEM: write_word(ins.address, src, ADV_MID);
            KIND_STORE_MEM_MEM: write_word(ins.second_address, word, ADV_LONG);
            KIND_LOAD_MEM_REG:  write_reg(ins.dst_reg, word, ADV_MID);
            KIND_ADD_LIT_REG:   write_reg(ins.dst_reg, dst + ins.literal, ADV_MID);
            KIND_ADD_REG_REG:   write_reg(ins.dst_reg, dst + src, ADV_SHORT);
            KIND_SUB_LIT_REG:   write_reg(ins.dst_reg, dst - ins.literal, ADV_MID);
            KIND_SUB_REG_REG:   write_reg(ins.dst_reg, dst - src, ADV_SHORT);
            KIND_INC_REG:       write_reg(ins.dst_reg, dst + 1'b1, ADV_TINY);
            KIND_INC_MEM:       write_word(ins.address, word + 1'b1, ADV_MEMRW);
            KIND_DEC_REG:       write_reg(ins.dst_reg, dst - 1'b1, ADV_TINY);
            KIND_DEC_MEM:       write_word(ins.address, word - 1'b1, ADV_MEMRW);
            KIND_JMP:           branch(1'b1, ins.address);
            KIND_JMP_NE:        branch(acc != cmp, ins.address);
            KIND_JMP_EQ:        branch(acc == cmp, ins.address);
            KIND_JMP_GT:        branch(acc > cmp, ins.address);
            KIND_JMP_LT:        branch(acc < cmp, ins.address);
            KIND_START:
            begin
                // last changed index is left alone
                arch_regs[IP_REG] = WORD_W'(ins.address);
                arch_running = 1'b1;
            end
            default:
            begin
                // halt, illegal and every unknown code
                arch_running = 1'b0;
                arch_regs[IP_REG] = arch_regs[IP_REG] + ADV_HALT;
                last_written = IP_REG;
            end
        endcase
        r.next_ip       = arch_regs[IP_REG];
        r.still_running = arch_running;
        r.changed_reg   = last_written;
        r.changed_value = arch_regs[last_written];
        r.r0_value      = arch_regs[R0_IDX];
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic trm_in_t instr(input logic [KIND_W-1:0] kind,
                                      input logic [WORD_W-1:0] lit,
                                      input logic [REG_AW-1:0] src,
                                      input logic [REG_AW-1:0] dst,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] addr2);
        trm_in_t ins;
        ins.kind           = kind;
        ins.literal        = lit;
        ins.src_reg        = src;
        ins.dst_reg        = dst;
        ins.address        = addr;
        ins.second_address = addr2;
        return ins;
    endfunction

    function automatic void add_row(input trm_in_t ins, input bit has_want,
                                    input trm_out_t want);
        directed_row_t row;
        row.ins      = ins;
        row.has_want = has_want;
        row.want     = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void track_writes(input trm_in_t ins);
        logic [ADDR_W-1:0] waddr;
        bit                writes;
        waddr  = ins.address;
        writes = 1'b0;
        case (ins.kind)
            KIND_STORE_LIT_MEM, KIND_STORE_REG_MEM, KIND_INC_MEM, KIND_DEC_MEM:
                writes = 1'b1;
            KIND_STORE_MEM_MEM:
            begin
                writes = 1'b1;
                waddr  = ins.second_address;
            end
            default:
                writes = 1'b0;
        endcase
        if (writes && !word_written[waddr])
        begin
            word_written[waddr] = 1'b1;
            written_addrs.push_back(int'(waddr));
        end
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        // favour a small pool so that words are reused
        return ADDR_W'($urandom_range(1) ? $urandom_range(15)
                                         : $urandom_range(MEM_DEPTH - 1));
    endfunction

    function automatic trm_in_t shape_instr(input logic [KIND_W-1:0] kind);
        trm_in_t ins;
        ins.kind = kind;
        case ($urandom_range(7))
            0, 1:    ins.literal = $urandom_range(3);
            2:       ins.literal = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            default: ins.literal = $urandom;
        endcase
        ins.src_reg        = ($urandom_range(3) == 0) ? ACC_REG
                                                      : REG_AW'($urandom_range(REG_SLOTS - 1));
        ins.dst_reg        = REG_AW'($urandom_range(REG_SLOTS - 1));
        ins.address        = random_addr();
        ins.second_address = random_addr();
        // steer reads onto words that hold a value
        if ((kind == KIND_STORE_MEM_MEM || kind == KIND_LOAD_MEM_REG ||
             kind == KIND_INC_MEM || kind == KIND_DEC_MEM) && !word_written[ins.address])
        begin
            if (written_addrs.size() == 0)
                ins.kind = KIND_STORE_LIT_MEM;
            else
                ins.address = ADDR_W'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
        end
        track_writes(ins);
        return ins;
    endfunction

    // Offer one beat, wait for it to be taken, then queue what it should produce.
    task automatic send_instr(input trm_in_t ins, input bit has_want, input trm_out_t want);
        int       gap;
        int       waited;
        trm_out_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= ins;
        item_valid <= 1'b1;
        waited = 0;
        @(posedge clk);
        while (item_stall)
        begin
            waited++;
            @(posedge clk);
        end
        predicted = execute_instr(ins);
        expected_res_q.push_back(has_want ? want : predicted);
        items_taken++;
        if (waited > longest_stall)
            longest_stall = waited;
    endtask

    // A start, a random body, and some way of stopping; now and then a stray beat.
    task automatic issue_program();
        int                body_len;
        logic [KIND_W-1:0] stop_kind;
        if ($urandom_range(99) < 15)
        begin
            send_instr(shape_instr(KIND_W'($urandom_range((1 << KIND_W) - 1))), 1'b0, '0);
        end
        else
        begin
            send_instr(shape_instr(KIND_START), 1'b0, '0);
            body_len = $urandom_range(3, 16);
            repeat (body_len)
                send_instr(shape_instr(KIND_W'($urandom_range(KIND_MOV_LIT_REG, KIND_JMP_LT))),
                           1'b0, '0);
            case ($urandom_range(9))
                0:       stop_kind = KIND_ILLEGAL;
                1:       stop_kind = KIND_W'($urandom_range(KIND_START + 1, (1 << KIND_W) - 1));
                default: stop_kind = KIND_HALT;
            endcase
            send_instr(shape_instr(stop_kind), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge clk or negedge rst_n)
    begin : result_check
        trm_out_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_res_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result beat %0d with nothing pending: ip %h run %b reg %0d",
                                 results_seen, res.next_ip, res.still_running,
                                 res.changed_reg);
                end
                else
                begin
                    want = expected_res_q.pop_front();
                    if (res.next_ip !== want.next_ip ||
                        res.still_running !== want.still_running ||
                        res.changed_reg !== want.changed_reg ||
                        res.changed_value !== want.changed_value ||
                        res.r0_value !== want.r0_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Result beat %0d wrong:", results_seen);
                            $display("  want ip %h run %b reg %0d val %h r0 %h",
                                     want.next_ip, want.still_running, want.changed_reg,
                                     want.changed_value, want.r0_value);
                            $display("  got  ip %h run %b reg %0d val %h r0 %h",
                                     res.next_ip, res.still_running, res.changed_reg,
                                     res.changed_value, res.r0_value);
                        end
                    end
                end
            end
            res_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long hold-off on the result side so the pipeline fills and backs up.
    initial
    begin : long_hold
        wait (hold_req);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin : stimulus
        int base;
        foreach (arch_regs[i])
            arch_regs[i] = '0;
        arch_running = 1'b0;
        last_written = R0_IDX;

        // extremes, every operation, pointer writes, halted execution, odd codes
        add_row(instr(KIND_START, '0, '0, '0, 10'd1023, '0), 1'b1,
                '{32'd1023, 1'b1, R0_IDX, 32'd0, 32'd0});
        add_row(instr(KIND_MOV_LIT_REG, 32'hFFFF_FFFF, '0, R0_IDX, '0, '0), 1'b1,
                '{32'd1029, 1'b1, R0_IDX, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        add_row(instr(KIND_ADD_LIT_REG, 32'd1, '0, R0_IDX, '0, '0), 1'b1,
                '{32'd1035, 1'b1, R0_IDX, 32'd0, 32'd0});
        add_row(instr(KIND_DEC_REG, '0, '0, R0_IDX, '0, '0), 1'b1,
                '{32'd1037, 1'b1, R0_IDX, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        add_row(instr(KIND_INC_REG, '0, '0, R0_IDX, '0, '0), 1'b1,
                '{32'd1039, 1'b1, R0_IDX, 32'd0, 32'd0});
        add_row(instr(KIND_MOV_LIT_REG, 32'h8000_0000, '0, ACC_REG, '0, '0), 1'b0, '0);
        add_row(instr(KIND_MOV_REG_REG, '0, ACC_REG, 4'd3, '0, '0), 1'b0, '0);
        add_row(instr(KIND_ADD_REG_REG, '0, 4'd3, ACC_REG, '0, '0), 1'b0, '0);
        add_row(instr(KIND_SUB_LIT_REG, 32'd1, '0, ACC_REG, '0, '0), 1'b0, '0);
        add_row(instr(KIND_SUB_REG_REG, '0, ACC_REG, 4'd3, '0, '0), 1'b0, '0);
        add_row(instr(KIND_STORE_LIT_MEM, 32'hFFFF_FFFF, '0, '0, 10'd1023, '0), 1'b0, '0);
        add_row(instr(KIND_STORE_REG_MEM, '0, ACC_REG, '0, 10'd0, '0), 1'b0, '0);
        add_row(instr(KIND_STORE_MEM_MEM, '0, '0, '0, 10'd1023, 10'd512), 1'b0, '0);
        add_row(instr(KIND_LOAD_MEM_REG, '0, '0, 4'd5, 10'd512, '0), 1'b0, '0);
        add_row(instr(KIND_INC_MEM, '0, '0, '0, 10'd1023, '0), 1'b0, '0);
        add_row(instr(KIND_DEC_MEM, '0, '0, '0, 10'd0, '0), 1'b0, '0);
        add_row(instr(KIND_JMP_NE, '0, ACC_REG, '0, 10'd100, '0), 1'b0, '0);
        add_row(instr(KIND_JMP_EQ, '0, ACC_REG, '0, 10'd1023, '0), 1'b0, '0);
        add_row(instr(KIND_JMP_GT, '0, R0_IDX, '0, 10'd200, '0), 1'b0, '0);
        add_row(instr(KIND_JMP_LT, '0, R0_IDX, '0, 10'd300, '0), 1'b0, '0);
        add_row(instr(KIND_JMP, '0, '0, '0, 10'd0, '0), 1'b0, '0);
        add_row(instr(KIND_MOV_LIT_REG, 32'hFFFF_FFFC, '0, IP_REG, '0, '0), 1'b0, '0);
        add_row(instr(KIND_HALT, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(instr(KIND_ADD_LIT_REG, 32'd7, '0, 4'd1, '0, '0), 1'b0, '0);
        add_row(instr(KIND_ILLEGAL, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(instr(KIND_W'((1 << KIND_W) - 1), 32'hFFFF_FFFF, 4'hF, 4'hF, 10'h3FF, 10'h3FF),
                1'b0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            track_writes(directed_rows[i].ins);
            send_instr(directed_rows[i].ins, directed_rows[i].has_want,
                       directed_rows[i].want);
        end

        // idle patterns: none, sender only, receiver only, both lightly
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 10 : 0;
            recv_stall_pct <= (ph == 2) ? 58 : (ph == 3) ? 10 : 0;
            base = items_taken;
            while (items_taken < base + PHASE_ITEMS)
                issue_program();
        end

        // keep offering beats while the result side is held off
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_req = 1'b1;
        base = items_taken;
        while (items_taken < base + PRESSURE_ITEMS)
            issue_program();

        item_valid <= 1'b0;
        while (expected_res_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d instructions (%0d from the directed table), %0d results checked.",
                 items_taken, directed_rows.size(), results_seen);
        $display("Branches taken %0d, longest input stall %0d cycles, mismatches %0d.",
                 taken_branches, longest_stall, mismatches);
        if (mismatches == 0 && expected_res_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
